>>> src/printf_integer_formatter_unit_macros.svh
// Assertion helpers for the printf integer formatter checker.
`ifndef PRINTF_INTEGER_FORMATTER_UNIT_MACROS_SVH
`define PRINTF_INTEGER_FORMATTER_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define PIFU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PIFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/pifu_pkg.sv
// ============================================================================
// pifu_pkg
// Shared constants for the printf integer formatter: character codes,
// flag bit positions and conversion sizes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pifu_pkg;

    localparam int unsigned DEF_MAX_WIDTH = 63;
    localparam int unsigned BCD_DIGITS    = 20;
    localparam int unsigned BIN_BITS      = 64;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam int unsigned FLAG_PLUS  = 0;
    localparam int unsigned FLAG_SPACE = 1;
    localparam int unsigned FLAG_MINUS = 2;
    localparam int unsigned FLAG_ZERO  = 3;

    typedef struct packed {
        logic       in_seq;
        logic [3:0] flags;
        logic       long_size;
        logic       pend_ell;
        logic [5:0] width;
        logic       reading;
    } t_seq;

endpackage

`default_nettype wire

>>> src/printf_integer_formatter_unit.sv
// A literal item is registered and shows at the output in the cycle after it is accepted.
// A d, i or u item runs the double-dabble conversion, drops leading zero digits
// down to one, lays out the field, then emits one character per cycle while the
// output is not stalled. Items are taken one at a time; the next item is taken
// once the current one's last character is in an unstalled output register.
// Reset: synchronous, active low; clears parse state and the output valid flag.
// ============================================================================
// printf_integer_formatter_unit
// Parses printf-style format characters and emits padded decimal integers,
// one output character per cycle while the output is not stalled, through a bit-serial binary to BCD unit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module printf_integer_formatter_unit
    import pifu_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_fmt_char,
    input  wire logic [63:0] i_arg_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_char,
    output logic             o_last_char
);

    localparam int unsigned LEN_W = $clog2(BCD_DIGITS + 1);
    localparam int unsigned BCD_W = 4 * BCD_DIGITS;

    typedef enum logic [2:0] {
        S_IDLE, S_ELL, S_LIT, S_CONV, S_TRIM, S_EMIT
    } t_state;

    t_state             r_state;
    t_seq               r_seq;
    logic               r_ov;
    logic [7:0]         r_och;
    logic               r_olast;
    logic [7:0]         r_lit;
    logic               r_litp;
    logic [63:0]        r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [5:0]         r_cnt;
    logic [LEN_W-1:0]   r_len;
    logic               r_sgn;
    logic [7:0]         r_sign_ch;
    logic [5:0]         r_pad;
    logic [5:0]         r_rem;

    logic               can_emit;
    logic               accept;
    logic               is_digit;
    logic [9:0]         w_acc;
    logic [5:0]         w_next;
    logic               conv_signed;
    logic [63:0]        arg_ext;
    logic               arg_neg;
    logic [63:0]        arg_mag;
    logic [BCD_W-1:0]   bcd_adj;
    logic [5:0]         tot;
    logic [5:0]         pad_calc;
    logic               sel_sign;
    logic               sel_pad;
    logic [7:0]         emit_ch;

    // Handshake
    assign can_emit = !r_ov || !i_stall;
    assign o_stall  = !(r_state == S_IDLE && can_emit);
    assign accept   = i_valid && !o_stall;

    // Width digits, saturating
    assign is_digit = (i_fmt_char >= CH_ZERO) && (i_fmt_char <= CH_NINE);
    assign w_acc    = 10'(r_seq.width) * 10'd10 + 10'(i_fmt_char[3:0]);
    assign w_next   = (w_acc > 10'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : w_acc[5:0];

    // Operand sizing and magnitude
    assign conv_signed = (i_fmt_char == CH_D) || (i_fmt_char == CH_I);
    assign arg_ext  = r_seq.long_size ? i_arg_value :
                      {{32{conv_signed & i_arg_value[31]}}, i_arg_value[31:0]};
    assign arg_neg  = conv_signed && arg_ext[63];
    assign arg_mag  = arg_neg ? (64'd0 - arg_ext) : arg_ext;

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                          : r_bcd[4*k +: 4];
        end
    end

    // Field layout
    assign tot      = 6'(r_len) + 6'(r_sgn);
    assign pad_calc = (r_seq.width > tot) ? r_seq.width - tot : 6'd0;

    // Pick the next character of the field
    always_comb begin
        sel_sign = 1'b0;
        sel_pad  = 1'b0;
        if (r_seq.flags[FLAG_MINUS]) begin
            sel_sign = r_sgn;
            sel_pad  = !r_sgn && (r_len == '0);
        end else if (r_seq.flags[FLAG_ZERO]) begin
            sel_sign = r_sgn;
            sel_pad  = !r_sgn && (r_pad != 6'd0);
        end else begin
            sel_pad  = (r_pad != 6'd0);
            sel_sign = !sel_pad && r_sgn;
        end
        if (sel_sign) begin
            emit_ch = r_sign_ch;
        end else if (sel_pad) begin
            emit_ch = (r_seq.flags[FLAG_ZERO] && !r_seq.flags[FLAG_MINUS]) ? CH_ZERO
                                                                           : CH_SPACE;
        end else begin
            emit_ch = CH_ZERO | {4'd0, r_bcd[BCD_W-1 -: 4]};
        end
    end

    // State, parse registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_seq   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (r_seq.pend_ell) begin
                            if (r_seq.in_seq && i_fmt_char == CH_L) begin
                                r_seq.pend_ell  <= 1'b0;
                                r_seq.long_size <= 1'b1;
                                r_seq.reading   <= 1'b0;
                            end else begin
                                r_ov    <= 1'b1;
                                r_och   <= CH_PCT;
                                r_olast <= 1'b0;
                                r_seq   <= '0;
                                r_lit   <= i_fmt_char;
                                if (i_fmt_char == CH_PCT) begin
                                    r_seq.in_seq <= 1'b1;
                                    r_litp       <= 1'b0;
                                end else begin
                                    r_litp <= 1'b1;
                                end
                                r_state <= S_ELL;
                            end
                        end else if (!r_seq.in_seq) begin
                            r_seq <= '0;
                            if (i_fmt_char == CH_PCT) begin
                                r_seq.in_seq <= 1'b1;
                            end else begin
                                r_ov    <= 1'b1;
                                r_och   <= i_fmt_char;
                                r_olast <= 1'b1;
                            end
                        end else if (r_seq.reading && is_digit) begin
                            r_seq.width <= w_next;
                        end else begin
                            r_seq.reading <= 1'b0;
                            case (i_fmt_char)
                                CH_PCT: begin
                                    r_ov    <= 1'b1;
                                    r_och   <= CH_PCT;
                                    r_olast <= 1'b1;
                                    r_seq   <= '0;
                                end
                                CH_PLUS:  r_seq.flags[FLAG_PLUS]  <= 1'b1;
                                CH_SPACE: r_seq.flags[FLAG_SPACE] <= 1'b1;
                                CH_MINUS: r_seq.flags[FLAG_MINUS] <= 1'b1;
                                CH_ZERO:  r_seq.flags[FLAG_ZERO]  <= 1'b1;
                                CH_L:     r_seq.pend_ell          <= 1'b1;
                                CH_D, CH_I, CH_U: begin
                                    r_bin     <= arg_mag;
                                    r_bcd     <= '0;
                                    r_cnt     <= 6'(BIN_BITS - 1);
                                    r_sgn     <= arg_neg || r_seq.flags[FLAG_PLUS]
                                                 || r_seq.flags[FLAG_SPACE];
                                    r_sign_ch <= arg_neg ? CH_MINUS :
                                                 r_seq.flags[FLAG_PLUS] ? CH_PLUS
                                                                        : CH_SPACE;
                                    r_state   <= S_CONV;
                                end
                                default: begin
                                    if (i_fmt_char >= CH_ONE && i_fmt_char <= CH_NINE) begin
                                        r_seq.width   <= 6'(i_fmt_char[3:0]);
                                        r_seq.reading <= 1'b1;
                                    end else begin
                                        r_ov    <= 1'b1;
                                        r_och   <= CH_PCT;
                                        r_olast <= 1'b0;
                                        r_lit   <= i_fmt_char;
                                        r_seq   <= '0;
                                        r_state <= S_LIT;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_ELL: begin
                    if (can_emit) begin
                        r_ov    <= 1'b1;
                        r_och   <= CH_L;
                        r_olast <= !r_litp;
                        r_state <= r_litp ? S_LIT : S_IDLE;
                    end
                end
                S_LIT: begin
                    if (can_emit) begin
                        r_ov    <= 1'b1;
                        r_och   <= r_lit;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CONV: begin
                    // Shift one binary bit into the BCD register
                    r_bcd <= {bcd_adj[BCD_W-2:0], r_bin[63]};
                    r_bin <= {r_bin[62:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_len   <= LEN_W'(BCD_DIGITS);
                        r_state <= S_TRIM;
                    end
                end
                S_TRIM: begin
                    // Drop leading zero digits, keep at least one
                    if (r_bcd[BCD_W-1 -: 4] == 4'd0 && r_len > LEN_W'(1)) begin
                        r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_len <= r_len - LEN_W'(1);
                    end else begin
                        r_pad   <= pad_calc;
                        r_rem   <= pad_calc + tot;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        r_ov    <= 1'b1;
                        r_och   <= emit_ch;
                        r_olast <= (r_rem == 6'd1);
                        r_rem   <= r_rem - 6'd1;
                        if (sel_sign) begin
                            r_sgn <= 1'b0;
                        end else if (sel_pad) begin
                            r_pad <= r_pad - 6'd1;
                        end else begin
                            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
                            r_len <= r_len - LEN_W'(1);
                        end
                        if (r_rem == 6'd1) begin
                            r_seq   <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ov;
    assign o_out_char  = r_och;
    assign o_last_char = r_olast;

endmodule

`default_nettype wire

>>> src/pifu_checker.sv
// ============================================================================
// pifu_checker
// Port-level checks for the printf integer formatter, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "printf_integer_formatter_unit_macros.svh"

module pifu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [7:0]  o_out_char,
    input wire logic        o_last_char
);

    // Hold a stalled output item
    `PIFU_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "output item dropped while stalled")
    `PIFU_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_out_char) && $stable(o_last_char), "stalled output item changed")
    // No new item while an item still has characters to emit
    `PIFU_ASSERT(a_busy_stall, i_clk, i_rst_n, o_valid && !o_last_char |-> o_stall, "input taken mid-item")
    // Reset empties the output register
    `PIFU_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind printf_integer_formatter_unit pifu_checker u_pifu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_char  (o_out_char),
    .o_last_char (o_last_char)
);

`default_nettype wire
